### rtl/wsf_pkg.sv
package wsf_pkg;

  // String size and node indexing
  localparam int MaxNodes = 64;
  localparam int NodeW    = $clog2(MaxNodes);
  localparam int CountW   = NodeW + 1;

  // Field and register widths
  localparam int DataW     = 32;
  localparam int PeakW     = 31;
  localparam int CfgDataW  = 32;
  localparam int CfgIdxW   = 2;
  localparam int NodesRegW = 7;
  localparam int CourantW  = 17;
  localparam int StepW     = 16;

  // Datapath widths: Laplacian, 2z - old, coefficient, product, sum
  localparam int FracW = 16;
  localparam int LapW  = DataW + 3;
  localparam int BaseW = DataW + 2;
  localparam int CoefW = CourantW + 1;
  localparam int ProdW = LapW + CoefW;
  localparam int RndW  = ProdW - FracW;
  localparam int SumW  = RndW + 2;

  localparam int CourantMax = 1 << FracW;
  localparam int RoundHalf  = 1 << (FracW - 1);

  localparam logic signed [DataW-1:0] DataMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] DataMin = {1'b1, {(DataW-1){1'b0}}};

  // Register reset values
  localparam logic [NodesRegW-1:0]       NodesReset   = 7'd32;
  localparam logic [CourantW-1:0]        CourantReset = 17'd65536;
  localparam logic signed [DataW-1:0]    ForceReset   = 32'sd655360;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_NUM_NODES = 2'd0,
    CFG_COURANT   = 2'd1,
    CFG_FORCE     = 2'd2
  } cfg_idx_t;

  // Read issue tag: issue count, node = count - 1
  typedef struct packed {
    logic              valid;
    logic [CountW-1:0] idx;
  } issue_tag_t;

  // Node tag travelling with the stencil pipeline
  typedef struct packed {
    logic             valid;
    logic [NodeW-1:0] node;
  } node_tag_t;

  // Per-step settings handed to the stencil unit
  typedef struct packed {
    logic signed [CoefW-1:0] coef;
    logic signed [DataW-1:0] force_val;
    logic [NodeW-1:0]        mid;
    logic [NodeW-1:0]        last;
    logic                    force_on;
  } step_cfg_t;

endpackage

### rtl/wsf_row_mem.sv
module wsf_row_mem (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 clr,
  input  logic                                 trim,
  input  logic [wsf_pkg::MaxNodes-1:0]         keep,
  input  logic                                 we,
  input  logic [wsf_pkg::NodeW-1:0]            waddr,
  input  logic signed [wsf_pkg::DataW-1:0]     wdata,
  input  logic                                 re,
  input  logic [wsf_pkg::NodeW-1:0]            raddr,
  output logic signed [wsf_pkg::DataW-1:0]     rdata
);

  logic signed [wsf_pkg::DataW-1:0] mem [wsf_pkg::MaxNodes];
  logic [wsf_pkg::MaxNodes-1:0]     vld;
  logic signed [wsf_pkg::DataW-1:0] rd_q;
  logic                             rd_vld;

  // Row storage, one write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  // Per-entry valid bits: an entry not written since a reset, a clear or a trim that dropped it reads as rest
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (trim) begin
        vld <= vld & keep;
      end
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rd_vld <= vld[raddr];
      end
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

### rtl/wsf_stencil.sv
module wsf_stencil (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  wsf_pkg::issue_tag_t              tag_in,
  input  logic signed [wsf_pkg::DataW-1:0] now_rd,
  input  logic signed [wsf_pkg::DataW-1:0] bef_rd,
  input  wsf_pkg::step_cfg_t               cfg,
  output wsf_pkg::node_tag_t               tag_out,
  output logic signed [wsf_pkg::DataW-1:0] res_out,
  output logic                             busy
);

  // Stage 2: three-tap window and old value
  logic signed [wsf_pkg::DataW-1:0] wp, wc, wn, bd;
  wsf_pkg::node_tag_t               t2;
  // Stage 3: Laplacian and 2z - old
  logic signed [wsf_pkg::LapW-1:0]  lap3;
  logic signed [wsf_pkg::BaseW-1:0] base3;
  wsf_pkg::node_tag_t               t3;
  logic                             edge3, frc3;
  // Stage 4: product
  logic signed [wsf_pkg::ProdW-1:0] prod4;
  logic signed [wsf_pkg::BaseW-1:0] base4;
  wsf_pkg::node_tag_t               t4;
  logic                             edge4, frc4;
  // Stage 4 combinational sum
  logic signed [wsf_pkg::ProdW-1:0] prod_rnd;
  logic signed [wsf_pkg::RndW-1:0]  rnd;
  logic signed [wsf_pkg::SumW-1:0]  sum;
  logic signed [wsf_pkg::DataW-1:0] sat;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      t2.valid      <= 1'b0;
      t3.valid      <= 1'b0;
      t4.valid      <= 1'b0;
      tag_out.valid <= 1'b0;
    end else if (adv) begin
      t2.valid      <= tag_in.valid && (tag_in.idx != '0);
      t3.valid      <= t2.valid;
      t4.valid      <= t3.valid;
      tag_out.valid <= t4.valid;
    end
  end

  // Window shifts in one node per issue
  always_ff @(posedge clk) begin
    if (adv && tag_in.valid) begin
      wp <= wc;
      wc <= wn;
      wn <= now_rd;
      bd <= bef_rd;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      t2.node      <= wsf_pkg::NodeW'(tag_in.idx - 1'b1);
      // stencil terms
      lap3         <= wsf_pkg::LapW'(wp) - (wsf_pkg::LapW'(wc) <<< 1) + wsf_pkg::LapW'(wn);
      base3        <= (wsf_pkg::BaseW'(wc) <<< 1) - wsf_pkg::BaseW'(bd);
      t3.node      <= t2.node;
      edge3        <= (t2.node == '0) || (t2.node == cfg.last);
      frc3         <= cfg.force_on && (t2.node == cfg.mid);
      // shared multiplier
      prod4        <= wsf_pkg::ProdW'(lap3 * cfg.coef);
      base4        <= base3;
      t4.node      <= t3.node;
      edge4        <= edge3;
      frc4         <= frc3;
      // rounded, summed, saturated
      res_out      <= edge4 ? '0 : sat;
      tag_out.node <= t4.node;
    end
  end

  // Round half up, add terms, saturate
  always_comb begin
    prod_rnd = prod4 + wsf_pkg::ProdW'(wsf_pkg::RoundHalf);
    rnd      = wsf_pkg::RndW'(prod_rnd >>> wsf_pkg::FracW);
    sum      = wsf_pkg::SumW'(rnd) + wsf_pkg::SumW'(base4)
             + (frc4 ? wsf_pkg::SumW'(cfg.force_val) : '0);
    if (sum > wsf_pkg::SumW'(wsf_pkg::DataMax)) begin
      sat = wsf_pkg::DataMax;
    end else if (sum < wsf_pkg::SumW'(wsf_pkg::DataMin)) begin
      sat = wsf_pkg::DataMin;
    end else begin
      sat = wsf_pkg::DataW'(sum);
    end
  end

  assign busy = t2.valid || t3.valid || t4.valid || tag_out.valid;

endmodule

### rtl/wave_string_fdtd_step.sv
// One time step of the explicit 1-D wave equation on a string held at zero at
// both ends. clear_string = 1 puts the string at rest and zeroes the step count
// with no results (the running peak is kept). clear_string = 0 advances one
// step and returns one word per node in use (node 0 first), each with the
// node's new Q16.16 displacement, the running peak magnitude and a last_node
// flag on the final node. Node updates go one per cycle, while out_ready does
// not stall the output, through a stencil unit with a single multiplier,
// reading the two rows from ping-pong memories; a stall on out_ready halts the
// whole unit. A new command is taken only once the previous step has left the
// unit. Registers: 0 num_nodes, 1 courant_squared, 2 force_term.
module wave_string_fdtd_step (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 clear_string,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wsf_pkg::NodeW-1:0]            node_number,
  output logic signed [wsf_pkg::DataW-1:0]     displacement,
  output logic [wsf_pkg::PeakW-1:0]            peak_magnitude,
  output logic                                 last_node,
  input  logic                                 cfg_write,
  input  logic [wsf_pkg::CfgIdxW-1:0]          cfg_index,
  input  logic [wsf_pkg::CfgDataW-1:0]         cfg_data
);

  localparam int NW = (wsf_pkg::CountW > wsf_pkg::NodesRegW) ?
                      wsf_pkg::CountW : wsf_pkg::NodesRegW;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t                             state, state_next;
  logic [wsf_pkg::NodesRegW-1:0]      num_nodes;
  logic [wsf_pkg::CourantW-1:0]       courant_squared;
  logic signed [wsf_pkg::DataW-1:0]   force_term;
  logic [wsf_pkg::StepW-1:0]          step_count;
  logic [wsf_pkg::PeakW-1:0]          peak_seen;
  logic [wsf_pkg::CountW-1:0]         k;
  logic                               bank_sel;
  wsf_pkg::issue_tag_t                tag1;
  wsf_pkg::node_tag_t                 tag5;
  wsf_pkg::step_cfg_t                 step_cfg;

  logic                               adv, accept, busy, drain_done, flip;
  logic [NW-1:0]                      n_raw, n_clamp;
  logic [wsf_pkg::CountW-1:0]         n_use;
  logic [wsf_pkg::MaxNodes-1:0]       keep;
  logic [wsf_pkg::NodeW-1:0]          now_addr, bef_addr;
  logic signed [wsf_pkg::DataW-1:0]   rd_a, rd_b, now_rd, bef_rd, res5;
  logic                               we_a, we_b, wr_en;
  logic [wsf_pkg::DataW-1:0]          mag;
  logic [wsf_pkg::PeakW-1:0]          mag_sat;

  // Handshake
  assign adv      = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Nodes in use: multiple of eight, clamped to 8 .. MaxNodes
  always_comb begin
    n_raw = NW'({num_nodes[wsf_pkg::NodesRegW-1:3], 3'b000});
    if (n_raw < NW'(8)) begin
      n_clamp = NW'(8);
    end else if (n_raw > NW'(wsf_pkg::MaxNodes)) begin
      n_clamp = NW'(wsf_pkg::MaxNodes);
    end else begin
      n_clamp = n_raw;
    end
    n_use = wsf_pkg::CountW'(n_clamp);
    for (int j = 0; j < wsf_pkg::MaxNodes; j++) begin
      keep[j] = (wsf_pkg::CountW'(j) < n_use);
    end
  end

  // Per-step settings
  always_comb begin
    step_cfg.coef      = courant_squared[wsf_pkg::CourantW-1] ?
                         wsf_pkg::CoefW'(wsf_pkg::CourantMax) :
                         {1'b0, courant_squared};
    step_cfg.force_val = force_term;
    step_cfg.mid       = wsf_pkg::NodeW'(n_use >> 1);
    step_cfg.last      = wsf_pkg::NodeW'(n_use - 1'b1);
    step_cfg.force_on  = (step_count == '0);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes       <= wsf_pkg::NodesReset;
      courant_squared <= wsf_pkg::CourantReset;
      force_term      <= wsf_pkg::ForceReset;
    end else if (cfg_write) begin
      unique case (wsf_pkg::cfg_idx_t'(cfg_index))
        wsf_pkg::CFG_NUM_NODES: num_nodes <= cfg_data[wsf_pkg::NodesRegW-1:0];
        wsf_pkg::CFG_COURANT:   courant_squared <= cfg_data[wsf_pkg::CourantW-1:0];
        wsf_pkg::CFG_FORCE:     force_term <= wsf_pkg::DataW'(cfg_data);
        default: ;
      endcase
    end
  end

  // Sequencer
  assign drain_done = !tag1.valid && !busy;
  assign flip       = (state == S_DRAIN) && drain_done;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept && !clear_string) state_next = S_RUN;
      S_RUN:   if (adv && (k == n_use)) state_next = S_DRAIN;
      S_DRAIN: if (drain_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      k          <= '0;
      tag1.valid <= 1'b0;
      bank_sel   <= 1'b0;
      step_count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        k <= '0;
      end else if ((state == S_RUN) && adv) begin
        k <= k + 1'b1;
      end
      if (adv) begin
        tag1.valid <= (state == S_RUN);
      end
      // the written row becomes the current one
      if (flip) begin
        bank_sel <= !bank_sel;
      end
      if (accept && clear_string) begin
        step_count <= '0;
      end else if (flip && (step_count != '1)) begin
        step_count <= step_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag1.idx <= k;
    end
  end

  // Row banks: bank_sel low means bank A holds the current row
  assign now_addr = k[wsf_pkg::NodeW-1:0];
  assign bef_addr = k[wsf_pkg::NodeW-1:0] - 1'b1;
  assign wr_en    = adv && tag5.valid;
  assign we_a     = wr_en && bank_sel;
  assign we_b     = wr_en && !bank_sel;

  wsf_row_mem u_bank_a (
    .clk   (clk),
    .rst   (rst),
    .clr   (accept && clear_string),
    .trim  (flip && bank_sel),
    .keep  (keep),
    .we    (we_a),
    .waddr (tag5.node),
    .wdata (res5),
    .re    (adv),
    .raddr (bank_sel ? bef_addr : now_addr),
    .rdata (rd_a)
  );

  wsf_row_mem u_bank_b (
    .clk   (clk),
    .rst   (rst),
    .clr   (accept && clear_string),
    .trim  (flip && !bank_sel),
    .keep  (keep),
    .we    (we_b),
    .waddr (tag5.node),
    .wdata (res5),
    .re    (adv),
    .raddr (bank_sel ? now_addr : bef_addr),
    .rdata (rd_b)
  );

  assign now_rd = bank_sel ? rd_b : rd_a;
  assign bef_rd = bank_sel ? rd_a : rd_b;

  wsf_stencil u_stencil (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .tag_in  (tag1),
    .now_rd  (now_rd),
    .bef_rd  (bef_rd),
    .cfg     (step_cfg),
    .tag_out (tag5),
    .res_out (res5),
    .busy    (busy)
  );

  // Magnitude, saturated to 31 bits
  always_comb begin
    mag     = res5[wsf_pkg::DataW-1] ? wsf_pkg::DataW'(-res5) : wsf_pkg::DataW'(res5);
    mag_sat = mag[wsf_pkg::DataW-1] ? '1 : mag[wsf_pkg::PeakW-1:0];
  end

  // Output word register and running peak
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      peak_seen <= '0;
    end else begin
      if (adv) begin
        out_valid <= tag5.valid;
      end
      if (wr_en && (mag_sat > peak_seen)) begin
        peak_seen <= mag_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_number  <= tag5.node;
      displacement <= res5;
      last_node    <= (tag5.node == step_cfg.last);
    end
  end

  assign peak_magnitude = peak_seen;

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!tag1.valid && !busy))
    else $error("command taken while the stencil unit holds work");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_node) |-> (node_number == step_cfg.last))
    else $error("last flag on a node other than the final one");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    (we_a || we_b) |-> (state != S_IDLE))
    else $error("row write while idle");

  a_one_bank: assert property (@(posedge clk) disable iff (rst)
    !(we_a && we_b))
    else $error("both row banks written at once");
`endif

endmodule

### bench/wsf_step_checker.sv
`timescale 1ns / 100ps

// Watches the command, result and register ports of the string stepper,
// keeps its own copy of the string and predicts every node word.
module wsf_step_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              clear_string,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [wsf_pkg::NodeW-1:0]         node_number,
  input  logic signed [wsf_pkg::DataW-1:0]  displacement,
  input  logic [wsf_pkg::PeakW-1:0]         peak_magnitude,
  input  logic                              last_node,
  input  logic                              cfg_write,
  input  logic [wsf_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [wsf_pkg::CfgDataW-1:0]      cfg_data,
  output int                                backlog,
  output int                                mismatches
);
  import wsf_pkg::*;

  typedef struct packed {
    logic [NodeW-1:0]        node;
    logic signed [DataW-1:0] disp;
    logic [PeakW-1:0]        peak;
    logic                    last;
  } node_word_t;

  localparam longint PeakCap = 64'h7FFF_FFFF;

  // Predicted string state
  logic signed [DataW-1:0] row_now    [MaxNodes];
  logic signed [DataW-1:0] row_before [MaxNodes];
  logic [StepW-1:0]        steps_taken;
  logic [PeakW-1:0]        peak_held;

  // Shadow of the registers
  logic [NodesRegW-1:0]    cfg_nodes;
  logic [CourantW-1:0]     cfg_courant;
  logic signed [DataW-1:0] cfg_force;

  node_word_t expected_nodes[$];
  int         fail_total = 0;

  assign mismatches = fail_total;

  task automatic rest_string();
    foreach (row_now[i]) begin
      row_now[i]    = '0;
      row_before[i] = '0;
    end
    steps_taken = '0;
  endtask

  // One stencil update over the nodes in use, queueing a word per node
  task automatic advance_string();
    logic signed [DataW-1:0] next_row [MaxNodes];
    int         n;
    int         mid;
    longint     c;
    longint     z;
    longint     lap;
    longint     v;
    longint     mag;
    node_word_t w;
    n = {cfg_nodes[NodesRegW-1:3], 3'b000};
    if (n < 8) n = 8;
    if (n > MaxNodes) n = MaxNodes;
    c = (cfg_courant > CourantMax) ? CourantMax : cfg_courant;
    mid = n / 2;
    foreach (next_row[i]) next_row[i] = '0;
    for (int i = 1; i + 1 < n; i++) begin
      z   = row_now[i];
      lap = longint'(row_now[i-1]) - 2 * z + longint'(row_now[i+1]);
      v   = 2 * z - longint'(row_before[i]) + ((lap * c + RoundHalf) >>> FracW);
      if (i == mid && steps_taken == 0) v += cfg_force;
      if (v > longint'(DataMax)) v = DataMax;
      if (v < longint'(DataMin)) v = DataMin;
      next_row[i] = v[DataW-1:0];
    end
    row_before = row_now;
    row_now    = next_row;
    if (steps_taken != {StepW{1'b1}}) steps_taken++;
    for (int i = 0; i < n; i++) begin
      mag = (row_now[i] < 0) ? -longint'(row_now[i]) : longint'(row_now[i]);
      if (mag > PeakCap) mag = PeakCap;
      if (mag > peak_held) peak_held = mag[PeakW-1:0];
      w.node = i[NodeW-1:0];
      w.disp = row_now[i];
      w.peak = peak_held;
      w.last = (i + 1 == n);
      expected_nodes.push_back(w);
    end
  endtask

  task automatic note_failure(input node_word_t w, input bit orphan);
    fail_total++;
    if (fail_total <= 10) begin
      if (orphan)
        $display("%0t: unexpected word node %0d disp %0d peak %0d last %0d", $time,
                 node_number, displacement, peak_magnitude, last_node);
      else
        $display("%0t: word wrong: expected node %0d disp %0d peak %0d last %0d,%s",
                 $time, w.node, w.disp, w.peak, w.last, " got");
      if (!orphan)
        $display("  actual node %0d disp %0d peak %0d last %0d",
                 node_number, displacement, peak_magnitude, last_node);
    end
  endtask

  always @(posedge clk) begin
    node_word_t w;
    if (rst) begin
      rest_string();
      peak_held   = '0;
      cfg_nodes   = NodesReset;
      cfg_courant = CourantReset;
      cfg_force   = ForceReset;
      expected_nodes.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          CFG_NUM_NODES: cfg_nodes   = cfg_data[NodesRegW-1:0];
          CFG_COURANT:   cfg_courant = cfg_data[CourantW-1:0];
          CFG_FORCE:     cfg_force   = cfg_data[DataW-1:0];
          default: ;
        endcase
      end
      // result words against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_nodes.size() == 0) begin
          w = '0;
          note_failure(w, 1'b1);
        end else begin
          w = expected_nodes.pop_front();
          if (node_number !== w.node || displacement !== w.disp ||
              peak_magnitude !== w.peak || last_node !== w.last)
            note_failure(w, 1'b0);
        end
      end
      // accepted commands
      if (in_valid && in_ready) begin
        if (clear_string) rest_string();
        else advance_string();
      end
    end
    backlog <= expected_nodes.size();
  end

endmodule

### bench/tb_wave_string_fdtd_step.sv
`timescale 1ns / 100ps

module tb_wave_string_fdtd_step;
  import wsf_pkg::*;

  localparam int DrainCycles = 100;
  localparam int SettleCap   = 200000;
  localparam logic [CfgIdxW-1:0] SpareIdx = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic                    clear_string = 1'b0;
  logic                    out_valid;
  logic                    out_ready    = 1'b0;
  logic [NodeW-1:0]        node_number;
  logic signed [DataW-1:0] displacement;
  logic [PeakW-1:0]        peak_magnitude;
  logic                    last_node;
  logic                    cfg_write    = 1'b0;
  logic [CfgIdxW-1:0]      cfg_index    = '0;
  logic [CfgDataW-1:0]     cfg_data     = '0;

  int backlog;
  int mismatches;
  int gap_pct   = 0;
  int stall_pct = 0;

  always #10 clk = ~clk;

  wave_string_fdtd_step dut (
    .clk, .rst, .in_valid, .in_ready, .clear_string,
    .out_valid, .out_ready, .node_number, .displacement, .peak_magnitude, .last_node,
    .cfg_write, .cfg_index, .cfg_data
  );

  wsf_step_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .clear_string,
    .out_valid, .out_ready, .node_number, .displacement, .peak_magnitude, .last_node,
    .cfg_write, .cfg_index, .cfg_data, .backlog, .mismatches
  );

  // receiver back-pressure
  always @(posedge clk)
    out_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);

  // one command word, with random idle cycles ahead of it
  task automatic send_word(input logic clr);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    clear_string <= clr;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid, wait for every predicted word, then let the unit drain
  task automatic settle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    // let the checker count the words of the last accepted command first
    @(negedge clk);
    while (backlog != 0 && waited < SettleCap) begin
      @(negedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // register bits above each field's width are filled with noise
  task automatic load_settings(input logic [NodesRegW-1:0] nodes,
                               input logic [CourantW-1:0] courant,
                               input logic [DataW-1:0] drive_force, input bit spare);
    write_reg(CFG_NUM_NODES, ($urandom & ~32'h7F) | nodes);
    write_reg(CFG_COURANT, ($urandom & ~32'h1FFFF) | courant);
    write_reg(CFG_FORCE, drive_force);
    if (spare) write_reg(SpareIdx, $urandom);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [NodesRegW-1:0] nodes_val;
    logic [CourantW-1:0]  courant_val;
    logic [DataW-1:0]     force_val;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: pluck at the middle, then clears, one back to back
    repeat (3) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b1);
    send_word(1'b0);

    // count below range, Courant above one, most negative pluck
    settle();
    load_settings(7'd7, 17'h1FFFF, DataMin, 1'b0);
    send_word(1'b1);
    repeat (3) send_word(1'b0);

    // count above range, no coupling, saturating positive pluck
    settle();
    load_settings(7'd127, 17'd0, DataMax, 1'b1);
    send_word(1'b1);
    repeat (3) send_word(1'b0);

    // count not a multiple of eight, coupling just below one
    settle();
    load_settings(7'd9, 17'd65535, 32'hFFFF_FFFF, 1'b0);
    send_word(1'b1);
    repeat (2) send_word(1'b0);

    // random phases, each with its own settings and idling
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case ($urandom_range(3))
        0: nodes_val = NodesRegW'(8 * $urandom_range(1, 3));
        1: nodes_val = NodesRegW'($urandom_range(0, 127));
        2: nodes_val = 7'd8;
        default: nodes_val = NodesRegW'($urandom_range(8, 24));
      endcase
      case ($urandom_range(3))
        0: courant_val = CourantW'(CourantMax);
        1: courant_val = CourantW'($urandom_range(0, 131071));
        default: courant_val = CourantW'($urandom_range(0, CourantMax));
      endcase
      if ($urandom_range(1)) force_val = $urandom;
      else force_val = $urandom_range(0, 1 << 21) - (1 << 20);
      load_settings(nodes_val, courant_val, force_val, phase == 5);
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 63; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 63; end
        default: begin gap_pct = 34; stall_pct = 34; end
      endcase
      for (int k = 0; k < 40; k++)
        send_word($urandom_range(11) == 0);
    end

    settle();
    if (mismatches == 0 && backlog == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
